// ----- rtl/pf2_pkg.sv -----
// Shared types and constants for the two-objective Pareto filter.
package pf2_pkg;

   localparam int VALUE_W = 32;
   localparam int SUM_W   = 40;

   // Starting bound of the best-sum search: 10000000 in 16-fraction-bit fixed point.
   localparam logic [SUM_W-1:0] BEST_START = 40'd10000000 << 16;

   typedef struct packed {
      logic [VALUE_W-1:0] fitness_value;
      logic [VALUE_W-1:0] cost_value;
      logic               last_entry;
   } req_type;

   typedef struct packed {
      logic [4:0] entry_index;
      logic       kept;
      logic [5:0] survivor_count;
      logic [4:0] best_entry;
      logic       final_result;
   } rsp_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_READ_I,
      ST_WAIT_I,
      ST_SCAN
   } state_type;

endpackage

// ----- rtl/pf2_store.sv -----
// Entry store: one write port and one registered read port for (fitness, cost) pairs.
module pf2_store #(
   parameter int ENTRIES = 32
) (
   input  logic                                 clock,
   input  pf2_pkg::mem_ctl_type                 mem_ctl,
   input  logic [$clog2(ENTRIES)-1:0]           mem_addr,
   input  logic [2*pf2_pkg::VALUE_W-1:0]        mem_wdata,
   output logic [2*pf2_pkg::VALUE_W-1:0]        mem_rdata
);

   logic [2*pf2_pkg::VALUE_W-1:0] entry_mem [ENTRIES];
   logic [2*pf2_pkg::VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         entry_mem[mem_addr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_ctl.rd_en) begin
         rd_data_ff <= entry_mem[mem_addr];
      end
   end

   assign mem_rdata = rd_data_ff;

endmodule

// ----- rtl/pf2_ctrl.sv -----
// Load sequencing, dominance scan, elimination flags and result register.
module pf2_ctrl #(
   parameter int ENTRIES = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  pf2_pkg::req_type                     req_item,
   output logic                                 busy,
   output pf2_pkg::mem_ctl_type                 mem_ctl,
   output logic [$clog2(ENTRIES)-1:0]           mem_addr,
   output logic [2*pf2_pkg::VALUE_W-1:0]        mem_wdata,
   input  logic [2*pf2_pkg::VALUE_W-1:0]        mem_rdata,
   output logic                                 rsp_strobe,
   output pf2_pkg::rsp_type                     rsp_item
);

   localparam int ADDR_W = $clog2(ENTRIES);
   localparam int CNT_W  = $clog2(ENTRIES + 1);
   localparam int VW     = pf2_pkg::VALUE_W;

   pf2_pkg::state_type state_ff, state_in;

   logic [CNT_W-1:0]           count_ff, count_in;
   logic [CNT_W-1:0]           n_ff, n_in;
   logic [ADDR_W-1:0]          i_ff, i_in;
   logic [CNT_W-1:0]           j_ff, j_in;
   logic [ADDR_W-1:0]          rd_idx_ff, rd_idx_in;
   logic [VW-1:0]              fi_ff, fi_in;
   logic [VW-1:0]              ci_ff, ci_in;
   logic [ENTRIES-1:0]         elim_ff, elim_in;
   logic [CNT_W-1:0]           surv_ff, surv_in;
   logic [pf2_pkg::SUM_W-1:0]  best_sum_ff, best_sum_in;
   logic [ADDR_W-1:0]          best_idx_ff, best_idx_in;
   logic                       rsp_strobe_ff, rsp_strobe_in;
   pf2_pkg::rsp_type           rsp_item_ff, rsp_item_in;

   logic                       accept;
   logic                       has_room;
   logic [CNT_W-1:0]           n_load;
   logic [VW-1:0]              rd_fit;
   logic [VW-1:0]              rd_cost;
   logic                       hit;
   logic                       last_cmp;
   logic                       scan_done;
   logic                       last_i;
   logic [pf2_pkg::SUM_W-1:0]  sum;
   logic                       take_best;
   logic [CNT_W-1:0]           surv_next;
   logic [ADDR_W-1:0]          best_idx_next;

   assign accept    = start && (state_ff == pf2_pkg::ST_LOAD);
   assign has_room  = count_ff < CNT_W'(ENTRIES);
   assign n_load    = count_ff + CNT_W'(has_room);
   assign rd_fit    = mem_rdata[2*VW-1:VW];
   assign rd_cost   = mem_rdata[VW-1:0];
   assign hit       = (rd_idx_ff != i_ff) && !elim_ff[rd_idx_ff]
                      && (fi_ff >= rd_fit) && (ci_ff >= rd_cost);
   assign last_cmp  = CNT_W'(rd_idx_ff) == (n_ff - CNT_W'(1));
   assign scan_done = (state_ff == pf2_pkg::ST_SCAN) && (hit || last_cmp);
   assign last_i    = CNT_W'(i_ff) == (n_ff - CNT_W'(1));
   assign sum       = pf2_pkg::SUM_W'({1'b0, fi_ff} + {1'b0, ci_ff});
   assign take_best = !hit && (sum < best_sum_ff);
   assign surv_next = surv_ff + CNT_W'(!hit);
   assign best_idx_next = take_best ? i_ff : best_idx_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pf2_pkg::ST_LOAD: begin
            if (accept && req_item.last_entry) begin
               state_in = pf2_pkg::ST_READ_I;
            end
         end
         pf2_pkg::ST_READ_I: begin
            state_in = pf2_pkg::ST_WAIT_I;
         end
         pf2_pkg::ST_WAIT_I: begin
            state_in = pf2_pkg::ST_SCAN;
         end
         pf2_pkg::ST_SCAN: begin
            if (scan_done) begin
               state_in = last_i ? pf2_pkg::ST_LOAD : pf2_pkg::ST_READ_I;
            end
         end
         default: begin
            state_in = pf2_pkg::ST_LOAD;
         end
      endcase
   end

   // store access
   always_comb begin
      mem_ctl.wr_en = 1'b0;
      mem_ctl.rd_en = 1'b0;
      mem_addr      = '0;
      mem_wdata     = {req_item.fitness_value, req_item.cost_value};
      case (state_ff)
         pf2_pkg::ST_LOAD: begin
            mem_ctl.wr_en = accept && has_room;
            mem_addr      = ADDR_W'(count_ff);
         end
         pf2_pkg::ST_READ_I: begin
            mem_ctl.rd_en = 1'b1;
            mem_addr      = i_ff;
         end
         pf2_pkg::ST_WAIT_I: begin
            mem_ctl.rd_en = 1'b1;
            mem_addr      = '0;
         end
         pf2_pkg::ST_SCAN: begin
            mem_ctl.rd_en = j_ff < n_ff;
            mem_addr      = ADDR_W'(j_ff);
         end
         default: begin
            mem_ctl.rd_en = 1'b0;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      count_in      = count_ff;
      n_in          = n_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      rd_idx_in     = mem_ctl.rd_en ? mem_addr : rd_idx_ff;
      fi_in         = fi_ff;
      ci_in         = ci_ff;
      elim_in       = elim_ff;
      surv_in       = surv_ff;
      best_sum_in   = best_sum_ff;
      best_idx_in   = best_idx_ff;
      rsp_strobe_in = scan_done;
      rsp_item_in   = rsp_item_ff;

      if (accept) begin
         count_in = n_load;
         if (req_item.last_entry) begin
            n_in        = n_load;
            i_in        = '0;
            elim_in     = '0;
            surv_in     = '0;
            best_sum_in = pf2_pkg::BEST_START;
            best_idx_in = '0;
         end
      end

      if (state_ff == pf2_pkg::ST_WAIT_I) begin
         fi_in = rd_fit;
         ci_in = rd_cost;
         j_in  = CNT_W'(1);
      end

      if ((state_ff == pf2_pkg::ST_SCAN) && (j_ff < n_ff)) begin
         j_in = j_ff + CNT_W'(1);
      end

      if (scan_done) begin
         elim_in[i_ff]  = hit;
         surv_in        = surv_next;
         best_idx_in    = best_idx_next;
         if (take_best) begin
            best_sum_in = sum;
         end
         rsp_item_in.entry_index    = 5'(i_ff);
         rsp_item_in.kept           = !hit;
         rsp_item_in.survivor_count = last_i ? 6'(surv_next) : 6'd0;
         rsp_item_in.best_entry     = last_i ? 5'(best_idx_next) : 5'd0;
         rsp_item_in.final_result   = last_i;
         if (last_i) begin
            count_in = '0;
         end else begin
            i_in = i_ff + ADDR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pf2_pkg::ST_LOAD;
         count_ff      <= '0;
         elim_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         elim_ff       <= elim_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      rd_idx_ff   <= rd_idx_in;
      fi_ff       <= fi_in;
      ci_ff       <= ci_in;
      surv_ff     <= surv_in;
      best_sum_ff <= best_sum_in;
      best_idx_ff <= best_idx_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign busy       = state_ff != pf2_pkg::ST_LOAD;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

endmodule

// ----- rtl/pareto_filter_two_objective.sv -----
// Top level of the two-objective Pareto filter.
// Pairs load one per cycle while busy is low. The pair that carries last_entry starts
// the elimination pass and raises busy. The pass reads the entry store through its single
// read port: entry i is fetched first and then compared against each stored entry in
// turn, stopping at the first entry that dominates it. Each entry's result leaves on
// rsp_strobe for one cycle, in the cycle after its scan ends; the final one also carries
// the survivor count and best index, and busy is already low in that same cycle. Results
// cannot be held off, and there is no clearing pass after reset.
module pareto_filter_two_objective #(
   parameter int ENTRIES = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  pf2_pkg::req_type  req_item,
   output logic              rsp_strobe,
   output pf2_pkg::rsp_type  rsp_item
);

   pf2_pkg::mem_ctl_type                mem_ctl;
   logic [$clog2(ENTRIES)-1:0]          mem_addr;
   logic [2*pf2_pkg::VALUE_W-1:0]       mem_wdata;
   logic [2*pf2_pkg::VALUE_W-1:0]       mem_rdata;

   pf2_store #(
      .ENTRIES (ENTRIES)
   ) u_store (
      .clock     (clock),
      .mem_ctl   (mem_ctl),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .mem_rdata (mem_rdata)
   );

   pf2_ctrl #(
      .ENTRIES (ENTRIES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_item   (req_item),
      .busy       (busy),
      .mem_ctl    (mem_ctl),
      .mem_addr   (mem_addr),
      .mem_wdata  (mem_wdata),
      .mem_rdata  (mem_rdata),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule
